// ===== hdl/ptaw_pkg.sv =====
// Shared constants, types and helpers for the parent table ancestor walker.
package ptaw_pkg;

   localparam int NODES      = 1024;
   localparam int MAX_CHAIN  = 63;
   localparam int ID_W       = 10;
   localparam int INDEX_W    = $clog2(NODES);
   localparam int CNT_W      = $clog2(MAX_CHAIN + 1);
   localparam int STEP_LIMIT = 2 * MAX_CHAIN;
   localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
   localparam int ROOT_ID    = 1;

   typedef logic [ID_W-1:0] id_type;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_CHAIN  = 2'd1,
      CMD_COMMON = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_LISTED         = 3'd0,
      STAT_FIRST_MISSING  = 3'd1,
      STAT_SECOND_MISSING = 3'd2,
      STAT_COMMON         = 3'd3,
      STAT_NONE           = 3'd4,
      STAT_ABORT          = 3'd5,
      STAT_LOADED         = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      WK_IDLE,
      WK_LOAD,
      WK_CHAIN,
      WK_CHAIN_ABORT,
      WK_PAIR_A,
      WK_PAIR_B,
      WK_PAIR_CMP,
      WK_PAIR_WAIT
   } walk_state_type;

   typedef struct packed {
      logic   wr;
      logic   rd;
      id_type addr;
      id_type data;
   } mem_req_type;

   typedef struct packed {
      logic eq;
      logic gt;
   } cmp_res_type;

   function automatic logic in_table(id_type id);
      return int'(id) < NODES;
   endfunction

endpackage

// ===== hdl/ptaw_table.sv =====
// Parent table memory with its clearing sweep after reset.
module ptaw_table (
   input  logic                 clock,
   input  logic                 reset,
   input  ptaw_pkg::mem_req_type req,
   output ptaw_pkg::id_type     rd_data,
   output logic                 clearing
);
   import ptaw_pkg::*;

   id_type             mem [NODES];
   id_type             rd_q_ff;
   logic               rd_hit_ff;
   logic               clearing_ff;
   logic [INDEX_W-1:0] clr_idx_ff;
   logic [INDEX_W-1:0] clr_idx_in;
   logic               clearing_in;
   logic [INDEX_W-1:0] idx;

   assign idx = INDEX_W'(req.addr);

   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == INDEX_W'(NODES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // Single port: the sweep owns it while clearing, the walker afterwards.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (req.wr && in_table(req.addr)) begin
         mem[idx] <= req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd && in_table(req.addr)) begin
         rd_q_ff <= mem[idx];
      end
      if (req.rd) begin
         rd_hit_ff <= in_table(req.addr);
      end
   end

   // Ids beyond the table read as having no parent.
   assign rd_data  = rd_hit_ff ? rd_q_ff : '0;
   assign clearing = clearing_ff;

endmodule

// ===== hdl/ptaw_cmp.sv =====
// Shared magnitude comparator used by both query walks.
module ptaw_cmp (
   input  ptaw_pkg::id_type      lhs,
   input  ptaw_pkg::id_type      rhs,
   output ptaw_pkg::cmp_res_type res
);
   import ptaw_pkg::*;

   always_comb begin
      res.eq = (lhs == rhs);
      res.gt = (lhs > rhs);
   end

endmodule

// ===== hdl/ptaw_walk.sv =====
// Command sequencer: loads, chain walks and common ancestor walks.
module ptaw_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  clearing,
   input  logic [1:0]            req_command,
   input  ptaw_pkg::id_type      req_node_a,
   input  ptaw_pkg::id_type      req_node_b,
   input  ptaw_pkg::id_type      req_child_one,
   input  ptaw_pkg::id_type      req_child_two,
   input  ptaw_pkg::id_type      req_child_three,
   input  ptaw_pkg::id_type      rd_data,
   output ptaw_pkg::mem_req_type mem_req,
   output logic                  busy,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output ptaw_pkg::id_type      rsp_node,
   output logic                  rsp_last
);
   import ptaw_pkg::*;

   walk_state_type state_ff, state_in;

   id_type            cur_ff, cur_in;
   id_type            t1_ff, t1_in;
   id_type            t2_ff, t2_in;
   id_type            kid0_ff, kid0_in;
   id_type            kid1_ff, kid1_in;
   id_type            kid2_ff, kid2_in;
   logic [1:0]        kid_idx_ff, kid_idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              side_ff, side_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   id_type            rsp_node_ff, rsp_node_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              chain_end;
   logic              step_end;
   id_type            cmp_lhs, cmp_rhs;
   id_type            kid_sel;
   cmp_res_type       cmp;

   assign busy      = clearing || (state_ff != WK_IDLE);
   assign accept    = start && !busy;
   assign chain_end = (count_ff >= CNT_W'(MAX_CHAIN));
   assign step_end  = (steps_ff >= STEP_W'(STEP_LIMIT));

   // The comparator checks candidates against each other in the common walk
   // and the fetched parent against the root in the chain walk.
   always_comb begin
      if (state_ff == WK_PAIR_CMP) begin
         cmp_lhs = t1_ff;
         cmp_rhs = t2_ff;
      end else begin
         cmp_lhs = rd_data;
         cmp_rhs = ID_W'(ROOT_ID);
      end
   end

   ptaw_cmp u_cmp (
      .lhs (cmp_lhs),
      .rhs (cmp_rhs),
      .res (cmp)
   );

   always_comb begin
      case (kid_idx_ff)
         2'd0:    kid_sel = kid0_ff;
         2'd1:    kid_sel = kid1_ff;
         default: kid_sel = kid2_ff;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         WK_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_LOAD:   state_in = WK_LOAD;
                  CMD_CHAIN:  state_in = WK_CHAIN;
                  CMD_COMMON: state_in = WK_PAIR_A;
                  default:    state_in = WK_IDLE;
               endcase
            end
         end
         WK_LOAD: begin
            if (kid_idx_ff == 2'd2) begin
               state_in = WK_IDLE;
            end
         end
         WK_CHAIN: begin
            if (count_ff == '0) begin
               if (rd_data == '0 || cmp.eq) begin
                  state_in = WK_IDLE;
               end
            end else if (cmp.eq) begin
               state_in = WK_IDLE;
            end else if (rd_data == '0 || chain_end) begin
               state_in = WK_CHAIN_ABORT;
            end
         end
         WK_CHAIN_ABORT: state_in = WK_IDLE;
         WK_PAIR_A:      state_in = WK_PAIR_B;
         WK_PAIR_B: begin
            if (t1_ff == '0 || rd_data == '0) begin
               state_in = WK_IDLE;
            end else begin
               state_in = WK_PAIR_CMP;
            end
         end
         WK_PAIR_CMP: begin
            if (cmp.eq || step_end) begin
               state_in = WK_IDLE;
            end else begin
               state_in = WK_PAIR_WAIT;
            end
         end
         WK_PAIR_WAIT: begin
            if (rd_data == '0) begin
               state_in = WK_IDLE;
            end else begin
               state_in = WK_PAIR_CMP;
            end
         end
         default: state_in = WK_IDLE;
      endcase
   end

   // Outputs, memory requests and datapath updates.
   always_comb begin
      mem_req       = '0;
      cur_in        = cur_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      kid0_in       = kid0_ff;
      kid1_in       = kid1_ff;
      kid2_in       = kid2_ff;
      kid_idx_in    = kid_idx_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      side_in       = side_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_ABORT;
      rsp_node_in   = '0;
      rsp_last_in   = 1'b0;
      case (state_ff)
         WK_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_LOAD: begin
                     t1_in      = req_node_a;
                     kid0_in    = req_child_one;
                     kid1_in    = req_child_two;
                     kid2_in    = req_child_three;
                     kid_idx_in = 2'd0;
                  end
                  CMD_CHAIN: begin
                     mem_req.rd   = 1'b1;
                     mem_req.addr = req_node_a;
                     cur_in       = req_node_a;
                     count_in     = '0;
                  end
                  CMD_COMMON: begin
                     mem_req.rd   = 1'b1;
                     mem_req.addr = req_node_a;
                     t2_in        = req_node_b;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_ABORT;
                     rsp_last_in   = 1'b1;
                  end
               endcase
            end
         end
         WK_LOAD: begin
            mem_req.wr   = (kid_sel != '0);
            mem_req.addr = kid_sel;
            mem_req.data = t1_ff;
            kid_idx_in   = kid_idx_ff + 1'b1;
            if (kid_idx_ff == 2'd2) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_LOADED;
               rsp_last_in   = 1'b1;
            end
         end
         WK_CHAIN: begin
            // The previous ancestor is held back until its own parent has been read,
            // so that its last flag is known when it goes out.
            if (count_ff == '0) begin
               if (rd_data == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_FIRST_MISSING;
                  rsp_last_in   = 1'b1;
               end else if (cmp.eq) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_NONE;
                  rsp_last_in   = 1'b1;
               end else begin
                  mem_req.rd   = 1'b1;
                  mem_req.addr = rd_data;
                  cur_in       = rd_data;
                  count_in     = count_ff + 1'b1;
               end
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_LISTED;
               rsp_node_in   = cur_ff;
               if (cmp.eq) begin
                  rsp_last_in = 1'b1;
               end else if (!(rd_data == '0 || chain_end)) begin
                  mem_req.rd   = 1'b1;
                  mem_req.addr = rd_data;
                  cur_in       = rd_data;
                  count_in     = count_ff + 1'b1;
               end
            end
         end
         WK_CHAIN_ABORT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_ABORT;
            rsp_last_in   = 1'b1;
         end
         WK_PAIR_A: begin
            t1_in        = rd_data;
            mem_req.rd   = 1'b1;
            mem_req.addr = t2_ff;
         end
         WK_PAIR_B: begin
            t2_in    = rd_data;
            steps_in = '0;
            if (t1_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_FIRST_MISSING;
               rsp_last_in   = 1'b1;
            end else if (rd_data == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_SECOND_MISSING;
               rsp_last_in   = 1'b1;
            end
         end
         WK_PAIR_CMP: begin
            if (cmp.eq) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_COMMON;
               rsp_node_in   = t1_ff;
               rsp_last_in   = 1'b1;
            end else if (step_end) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_ABORT;
               rsp_last_in   = 1'b1;
            end else begin
               mem_req.rd   = 1'b1;
               mem_req.addr = cmp.gt ? t1_ff : t2_ff;
               side_in      = cmp.gt;
               steps_in     = steps_ff + 1'b1;
            end
         end
         WK_PAIR_WAIT: begin
            if (side_ff) begin
               t1_in = rd_data;
            end else begin
               t2_in = rd_data;
            end
            if (rd_data == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_ABORT;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      t1_ff         <= t1_in;
      t2_ff         <= t2_in;
      kid0_ff       <= kid0_in;
      kid1_ff       <= kid1_in;
      kid2_ff       <= kid2_in;
      kid_idx_ff    <= kid_idx_in;
      count_ff      <= count_in;
      steps_ff      <= steps_in;
      side_ff       <= side_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_node   = rsp_node_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== hdl/parent_table_ancestor_walker.sv =====
// Top level of the parent table ancestor walker.
//
// A transaction is taken when start is high and busy is low. Command 0 stores
// node_a as the parent of each nonzero child; command 1 lists the ancestors of
// node_a up to but not including the root; command 2 finds the nearest common
// ancestor of node_a and node_b. Any other command answers with an abort.
// Results appear on the rsp_ ports for one cycle each, flagged by rsp_valid,
// and the final result of a transaction has rsp_last set. The receiver cannot
// hold results off; results simply stream out when they are ready.
// A load writes one table entry for each nonzero child, then gives its result.
// A chain query reads the parent of node_a first and then gives
// one result per cycle, one table read per ancestor, up to 63 ancestors. A
// common query first fetches both parents and then works in steps (compare,
// then table read), at most 126 steps. The single table port and its
// registered read set the pace of both walks. An unknown command never leaves
// the idle state. After reset the table is cleared by a sweep over all 1024
// entries, one entry per cycle, during which busy stays high.
module parent_table_ancestor_walker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_command,
   input  ptaw_pkg::id_type req_node_a,
   input  ptaw_pkg::id_type req_node_b,
   input  ptaw_pkg::id_type req_child_one,
   input  ptaw_pkg::id_type req_child_two,
   input  ptaw_pkg::id_type req_child_three,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output ptaw_pkg::id_type rsp_node,
   output logic             rsp_last
);
   import ptaw_pkg::*;

   mem_req_type mem_req;
   id_type      rd_data;
   logic        clearing;

   ptaw_table u_table (
      .clock    (clock),
      .reset    (reset),
      .req      (mem_req),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   ptaw_walk u_walk (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .clearing        (clearing),
      .req_command     (req_command),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_child_one   (req_child_one),
      .req_child_two   (req_child_two),
      .req_child_three (req_child_three),
      .rd_data         (rd_data),
      .mem_req         (mem_req),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_node        (rsp_node),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== hdl/ptaw_check.sv =====
// Port-level checker for the parent table ancestor walker, bound to the top.
module ptaw_check (
   input logic             clock,
   input logic             reset,
   input logic             busy,
   input logic             rsp_valid,
   input logic [2:0]       rsp_status,
   input ptaw_pkg::id_type rsp_node,
   input logic             rsp_last
);
   import ptaw_pkg::*;

   // The table clear keeps the block busy right after reset.
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("block not busy after reset");

   // More results of a transaction follow, so no new one may be taken.
   a_busy_mid_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("not busy while a transaction still has results");

   // Only listed ancestors may be non-final, and they are never 0 or the root.
   a_listed_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_LISTED |-> rsp_node != '0 && rsp_node != ID_W'(ROOT_ID))
      else $error("listed ancestor is zero or the root");

   a_nonlisted_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_LISTED |-> rsp_last)
      else $error("status other than listed without last");

   a_node_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_LISTED && rsp_status != STAT_COMMON
      |-> rsp_node == '0)
      else $error("node nonzero for a status that carries no node");

endmodule

bind parent_table_ancestor_walker ptaw_check u_ptaw_check (.*);
